### design/rk4d_pkg.sv
// Package for the RK4 drag trajectory step: widths, payload structs, opcodes.
package rk4d_pkg;

  localparam int WORD_BITS = 48;
  localparam int FRAC_BITS = 24;
  localparam int DRAG_BITS = 25;
  localparam int GRAV_BITS = 29;
  localparam int STEP_BITS = 25;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = 29;
  localparam logic [GRAV_BITS-1:0] GRAVITY_RESET = 29'd164584489;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_DRAG    = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GRAVITY = 1'b1;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic                 operation;
    logic [STEP_BITS-1:0] step_size;
    word_t                load_x;
    word_t                load_y;
    word_t                load_z;
    word_t                load_vx;
    word_t                load_vy;
    word_t                load_vz;
  } in_item_t;

  typedef struct packed {
    word_t out_x;
    word_t out_y;
    word_t out_z;
    word_t out_vx;
    word_t out_vy;
    word_t out_vz;
    logic  saturated;
  } out_item_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Saturating add of two words; ovf flags clipping
  function automatic word_t sat_add(input word_t a, input word_t b, output logic ovf);
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    ovf = s[WORD_BITS] != s[WORD_BITS-1];
    if (ovf) sat_add = s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    else sat_add = s[WORD_BITS-1:0];
  endfunction

endpackage

### design/rk4_drag_trajectory_step.sv
// RK4 step under gravity and quadratic drag: sequencer around one shared multiplier.
// A step item runs four derivative passes, each with a 56-bit bit-serial square root,
// 48x48 products as four 24x24 partial products on one multiplier, and a divide by six
// as a reciprocal product; a load item only stores the state and returns it.
// No new item is taken until the last result is taken: in_stall is high until then.
// Reset (synchronous, rst_n low) clears the state to zero, drag to 0, gravity to 9.81.
module rk4_drag_trajectory_step (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  rk4d_pkg::in_item_t                   in_item,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output rk4d_pkg::out_item_t                  out_item,
  input  logic                                 cfg_we,
  input  logic [rk4d_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [rk4d_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int W = rk4d_pkg::WORD_BITS;
  localparam int F = rk4d_pkg::FRAC_BITS;
  localparam int H = W / 2;
  localparam int PW = 2 * W;

  // Divide by six: ceil(2^50 / 6), exact floor for magnitudes up to 2^47
  localparam int RSH = 50;
  localparam logic [W-1:0] DIV6_RECIP = 48'd187649984473771;

  // Sequencer states
  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_SQ     = 5'd1;   // squares of velocity
  localparam logic [4:0] ST_SQRT   = 5'd2;   // bit-serial root
  localparam logic [4:0] ST_DRAG1  = 5'd3;   // drag * v
  localparam logic [4:0] ST_DRAG2  = 5'd4;   // (drag*v) * speed
  localparam logic [4:0] ST_TEMP   = 5'd5;   // t = s + h*k
  localparam logic [4:0] ST_FIN    = 5'd6;   // dt * sum
  localparam logic [4:0] ST_DIV    = 5'd7;   // divide by six
  localparam logic [4:0] ST_OUT    = 5'd8;
  localparam logic [4:0] ST_MUL    = 5'd9;   // multiplier busy

  logic [4:0] state_r, state_nxt, ret_r, ret_nxt;
  logic [1:0] pass_r, pass_nxt;     // derivative pass 0..3
  logic [2:0] lane_r, lane_nxt;     // element 0..5

  rk4d_pkg::word_t s_r [6];
  rk4d_pkg::word_t s_nxt [6];
  rk4d_pkg::word_t t_r [6];
  rk4d_pkg::word_t t_nxt [6];
  rk4d_pkg::word_t k_r [6];
  rk4d_pkg::word_t k_nxt [6];
  rk4d_pkg::word_t acc_r [6];
  rk4d_pkg::word_t acc_nxt [6];
  logic [rk4d_pkg::DRAG_BITS-1:0] drag_r, drag_nxt;
  logic [rk4d_pkg::GRAV_BITS-1:0] grav_r, grav_nxt;
  logic [rk4d_pkg::STEP_BITS-1:0] dt_r, dt_nxt;
  logic flag_r, flag_nxt;
  logic out_valid_r, out_valid_nxt;
  rk4d_pkg::word_t sp_r, sp_nxt;     // speed or sum of squares
  rk4d_pkg::word_t tmp_r, tmp_nxt;

  // Root registers: 56-bit result, 112-bit radicand window
  logic [55:0]  root_r, root_nxt;
  logic [57:0]  rem_r, rem_nxt;
  logic [111:0] rad_r, rad_nxt;
  logic [5:0]   rcnt_r, rcnt_nxt;

  // Shared multiplier: magnitudes split into 24-bit halves, one partial product a cycle
  logic [W-1:0] ma_r, ma_nxt, mb_r, mb_nxt;
  logic         mneg_r, mneg_nxt;
  logic [1:0]   mcnt_r, mcnt_nxt;
  logic [PW-1:0] macc_r, macc_nxt;
  logic [H-1:0] mop_a, mop_b;
  logic [W-1:0] mprod;

  // Sign of the value being divided by six
  logic         dneg_r, dneg_nxt;

  always_comb begin
    unique case (mcnt_r)
      2'd0: begin mop_a = ma_r[H-1:0]; mop_b = mb_r[H-1:0]; end
      2'd1: begin mop_a = ma_r[H-1:0]; mop_b = mb_r[W-1:H]; end
      2'd2: begin mop_a = ma_r[W-1:H]; mop_b = mb_r[H-1:0]; end
      default: begin mop_a = ma_r[W-1:H]; mop_b = mb_r[W-1:H]; end
    endcase
    mprod = mop_a * mop_b;
  end

  // Finished Q product with saturation
  function automatic rk4d_pkg::word_t mul_res(input logic [PW-1:0] p, input logic neg,
                                              output logic ovf);
    logic [PW-F-1:0] m;
    logic [W:0] lim;
    m = p[PW-1:F];
    lim = {2'b00, {(W-1){1'b1}}} + {{W{1'b0}}, neg};
    ovf = (m[PW-F-1:W] != '0) || ({1'b0, m[W-1:0]} > lim);
    if (ovf) mul_res = neg ? rk4d_pkg::WORD_MIN : rk4d_pkg::WORD_MAX;
    else if (neg) mul_res = -m[W-1:0];
    else mul_res = m[W-1:0];
  endfunction

  function automatic logic [W-1:0] mag(input rk4d_pkg::word_t v);
    mag = v[W-1] ? -v : v;
  endfunction

  // Start a multiply of a and b, returning to st afterwards
  task automatic start_mul(input rk4d_pkg::word_t a, input rk4d_pkg::word_t b,
                           input logic [4:0] st);
    ma_nxt = mag(a);
    mb_nxt = mag(b);
    mneg_nxt = a[W-1] ^ b[W-1];
    mcnt_nxt = 2'd0;
    macc_nxt = '0;
    ret_nxt = st;
    state_nxt = ST_MUL;
  endtask

  rk4d_pkg::word_t mres, ares, gneg, sumv, k2v, dtw, hw, qv;
  logic mo, ao, a2;
  logic [1:0] c1;
  logic [57:0] trial;

  assign in_stall  = (state_r != ST_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  always_comb begin
    out_item.out_x = s_r[0];
    out_item.out_y = s_r[1];
    out_item.out_z = s_r[2];
    out_item.out_vx = s_r[3];
    out_item.out_vy = s_r[4];
    out_item.out_vz = s_r[5];
    out_item.saturated = flag_r;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r; ret_nxt = ret_r; pass_nxt = pass_r; lane_nxt = lane_r;
    s_nxt = s_r; t_nxt = t_r; k_nxt = k_r; acc_nxt = acc_r;
    drag_nxt = drag_r; grav_nxt = grav_r; dt_nxt = dt_r; flag_nxt = flag_r;
    out_valid_nxt = out_valid_r; sp_nxt = sp_r; tmp_nxt = tmp_r;
    root_nxt = root_r; rem_nxt = rem_r; rad_nxt = rad_r; rcnt_nxt = rcnt_r;
    ma_nxt = ma_r; mb_nxt = mb_r; mneg_nxt = mneg_r; mcnt_nxt = mcnt_r; macc_nxt = macc_r;
    dneg_nxt = dneg_r;
    mres = mul_res(macc_r, mneg_r, mo);
    ares = '0; ao = 1'b0; a2 = 1'b0; gneg = '0; sumv = '0; k2v = '0; c1 = 2'd0; qv = '0;
    dtw = {{(W-rk4d_pkg::STEP_BITS){1'b0}}, dt_r};
    hw = dtw >>> 1;
    trial = {rem_r[55:0], rad_r[111:110]} - {root_r, 2'b01};

    if (cfg_we) begin
      unique case (cfg_index)
        rk4d_pkg::REG_DRAG:    drag_nxt = cfg_data[rk4d_pkg::DRAG_BITS-1:0];
        rk4d_pkg::REG_GRAVITY: grav_nxt = cfg_data[rk4d_pkg::GRAV_BITS-1:0];
        default: ;
      endcase
    end
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          flag_nxt = 1'b0;
          if (in_item.operation == rk4d_pkg::OP_LOAD) begin
            s_nxt[0] = in_item.load_x;  s_nxt[1] = in_item.load_y;
            s_nxt[2] = in_item.load_z;  s_nxt[3] = in_item.load_vx;
            s_nxt[4] = in_item.load_vy; s_nxt[5] = in_item.load_vz;
            state_nxt = ST_OUT;
          end else begin
            dt_nxt = in_item.step_size;
            t_nxt = s_r;
            pass_nxt = 2'd0; lane_nxt = 3'd0; sp_nxt = '0;
            for (int i = 0; i < 6; i++) acc_nxt[i] = '0;
            state_nxt = ST_SQ;
          end
        end
      end
      ST_MUL: begin
        unique case (mcnt_r)
          2'd0: macc_nxt = macc_r + {{(PW-W){1'b0}}, mprod};
          2'd3: macc_nxt = macc_r + {mprod, {W{1'b0}}};
          default: macc_nxt = macc_r + {{H{1'b0}}, mprod, {H{1'b0}}};
        endcase
        mcnt_nxt = mcnt_r + 2'd1;
        if (mcnt_r == 2'd3) state_nxt = ret_r;
      end
      ST_SQ: begin
        // Start v*v, then on return accumulate
        if (lane_r[2]) begin
          // lane 4: sum of squares finished (sp_r)
          rad_nxt = {{(112-W-F){1'b0}}, sp_r, {F{1'b0}}};
          root_nxt = '0; rem_nxt = '0; rcnt_nxt = 6'd0;
          state_nxt = ST_SQRT;
        end else if (lane_r[0] == 1'b0 && lane_r[1] == 1'b0 && tmp_r == '0 && ret_r != ST_SQ) begin
          start_mul(t_r[3], t_r[3], ST_SQ);
          tmp_nxt = rk4d_pkg::word_t'(1);
        end else begin
          // A product is ready
          flag_nxt = flag_nxt | mo;
          ares = rk4d_pkg::sat_add(sp_r, mres, ao);
          sp_nxt = ares; flag_nxt = flag_nxt | ao;
          if (lane_r == 3'd2) begin
            lane_nxt = 3'd4; ret_nxt = ST_IDLE; tmp_nxt = '0;
          end else begin
            lane_nxt = lane_r + 3'd1;
            start_mul(t_r[3'd4 + lane_r], t_r[3'd4 + lane_r], ST_SQ);
          end
        end
      end
      ST_SQRT: begin
        // One result bit per cycle over 56 bits
        if (trial[57] == 1'b0) begin
          rem_nxt = trial; root_nxt = {root_r[54:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[55:0], rad_r[111:110]}; root_nxt = {root_r[54:0], 1'b0};
        end
        rad_nxt = {rad_r[109:0], 2'b00};
        rcnt_nxt = rcnt_r + 6'd1;
        if (rcnt_r == 6'd55) begin
          if (root_nxt > {8'd0, rk4d_pkg::WORD_MAX}) begin
            sp_nxt = rk4d_pkg::WORD_MAX; flag_nxt = 1'b1;
          end else sp_nxt = root_nxt[W-1:0];
          lane_nxt = 3'd0;
          start_mul({{(W-rk4d_pkg::DRAG_BITS){1'b0}}, drag_r}, t_r[3], ST_DRAG1);
        end
      end
      ST_DRAG1: begin
        flag_nxt = flag_nxt | mo;
        start_mul(mres, sp_r, ST_DRAG2);
      end
      ST_DRAG2: begin
        flag_nxt = flag_nxt | mo;
        if (mres == rk4d_pkg::WORD_MIN) begin
          k_nxt[3'd3 + lane_r] = rk4d_pkg::WORD_MAX; flag_nxt = 1'b1;
        end else k_nxt[3'd3 + lane_r] = -mres;
        k_nxt[lane_r] = t_r[3'd3 + lane_r];
        if (lane_r == 3'd1) begin
          gneg = -{{(W-rk4d_pkg::GRAV_BITS){1'b0}}, grav_r};
          ares = rk4d_pkg::sat_add(k_nxt[4], gneg, ao);
          k_nxt[4] = ares; flag_nxt = flag_nxt | ao;
        end
        if (lane_r == 3'd2) begin
          // Accumulate weighted k, then form the next temp state, or after the last pass start dt * sum
          for (int i = 0; i < 6; i++) begin
            k2v = rk4d_pkg::sat_add(acc_r[i], k_nxt[i], a2);
            c1[0] = a2;
            if (pass_r == 2'd1 || pass_r == 2'd2) begin
              k2v = rk4d_pkg::sat_add(k2v, k_nxt[i], a2);
              c1[1] = a2;
            end
            acc_nxt[i] = k2v;
            if (c1 != 2'd0) flag_nxt = 1'b1;
          end
          lane_nxt = 3'd0;
          if (pass_r == 2'd3) begin
            start_mul(dtw, acc_nxt[0], ST_FIN);
          end else begin
            start_mul((pass_r == 2'd2) ? dtw : hw, k_nxt[0], ST_TEMP);
          end
        end else begin
          lane_nxt = lane_r + 3'd1;
          start_mul({{(W-rk4d_pkg::DRAG_BITS){1'b0}}, drag_r}, t_r[3'd4 + lane_r],
                    ST_DRAG1);
        end
      end
      ST_TEMP: begin
        flag_nxt = flag_nxt | mo;
        ares = rk4d_pkg::sat_add(s_r[lane_r], mres, ao);
        t_nxt[lane_r] = ares; flag_nxt = flag_nxt | ao;
        if (lane_r == 3'd5) begin
          pass_nxt = pass_r + 2'd1; lane_nxt = 3'd0; sp_nxt = '0;
          tmp_nxt = '0; ret_nxt = ST_IDLE;
          state_nxt = ST_SQ;
        end else begin
          lane_nxt = lane_r + 3'd1;
          start_mul((pass_r == 2'd2) ? dtw : hw, k_r[lane_r + 3'd1], ST_TEMP);
        end
      end
      ST_FIN: begin
        flag_nxt = flag_nxt | mo;
        dneg_nxt = mres[W-1];
        // Magnitude times the scaled reciprocal of six on the shared multiplier
        ma_nxt = mag(mres); mb_nxt = DIV6_RECIP; mneg_nxt = 1'b0;
        mcnt_nxt = 2'd0; macc_nxt = '0;
        ret_nxt = ST_DIV; state_nxt = ST_MUL;
      end
      ST_DIV: begin
        // Quotient truncated toward zero, then added to the state
        qv = {{(W-(PW-RSH)){1'b0}}, macc_r[PW-1:RSH]};
        sumv = dneg_r ? -qv : qv;
        ares = rk4d_pkg::sat_add(s_r[lane_r], sumv, ao);
        s_nxt[lane_r] = ares; flag_nxt = flag_nxt | ao;
        if (lane_r == 3'd5) state_nxt = ST_OUT;
        else begin
          lane_nxt = lane_r + 3'd1;
          start_mul(dtw, acc_r[lane_r + 3'd1], ST_FIN);
        end
      end
      ST_OUT: begin
        out_valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; ret_r <= ST_IDLE; pass_r <= '0; lane_r <= '0;
      out_valid_r <= 1'b0; flag_r <= 1'b0; tmp_r <= '0;
      drag_r <= '0; grav_r <= rk4d_pkg::GRAVITY_RESET;
      for (int i = 0; i < 6; i++) s_r[i] <= '0;
    end else begin
      state_r <= state_nxt; ret_r <= ret_nxt; pass_r <= pass_nxt; lane_r <= lane_nxt;
      out_valid_r <= out_valid_nxt; flag_r <= flag_nxt; tmp_r <= tmp_nxt;
      drag_r <= drag_nxt; grav_r <= grav_nxt;
      s_r <= s_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    t_r <= t_nxt; k_r <= k_nxt; acc_r <= acc_nxt; dt_r <= dt_nxt; sp_r <= sp_nxt;
    root_r <= root_nxt; rem_r <= rem_nxt; rad_r <= rad_nxt; rcnt_r <= rcnt_nxt;
    ma_r <= ma_nxt; mb_r <= mb_nxt; mneg_r <= mneg_nxt; mcnt_r <= mcnt_nxt;
    macc_r <= macc_nxt;
    dneg_r <= dneg_nxt;
  end

`ifndef NO_ASSERTIONS
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(s_r[0]) && $stable(flag_r)))
    else $error("result changed while stalled");
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_item.operation == rk4d_pkg::OP_LOAD) |=> ##1 out_valid_r)
    else $error("load result late");
  a_mul_return: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (ret_r != ST_MUL && ret_r != ST_IDLE))
    else $error("multiplier has no return state");
`endif

endmodule
